>>> src/prst_pkg.sv
// Package for the pending request slot table.
// Holds the table sizes, request and slot codes and the command word
// passed from the front end to the slot engine. No dependencies.
`timescale 1ns / 1ps

package prst_pkg;

   localparam int SLOTS       = 16;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int TAG_W       = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_ID = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ID_LIMIT    = 1'd1;

   localparam logic [31:0] RESERVED_ID_RESET = 32'd0;
   localparam logic [31:0] ID_LIMIT_RESET    = 32'd65536;

   typedef enum logic [3:0] {
      REQ_CREATE     = 4'd0,
      REQ_ACQUIRE    = 4'd1,
      REQ_MALLOC     = 4'd2,
      REQ_RELEASE    = 4'd3,
      REQ_FREE       = 4'd4,
      REQ_RESPONSE   = 4'd5,
      REQ_STATUS     = 4'd6,
      REQ_COMPLETE   = 4'd7,
      REQ_TERMINATE  = 4'd8,
      REQ_INITIALIZE = 4'd9
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BUSY    = 3'd1,
      ST_READY   = 3'd2,
      ST_NOSLOT  = 3'd3,
      ST_BADID   = 3'd4,
      ST_NOINIT  = 3'd5,
      ST_BADTAG  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      CODE_FREE       = 3'd0,
      CODE_CREATE     = 3'd1,
      CODE_ACQ_RD     = 3'd2,
      CODE_ACQ_WR     = 3'd3,
      CODE_MALLOC     = 3'd4,
      CODE_DATA_RDY   = 3'd5,
      CODE_MALLOC_RDY = 3'd6,
      CODE_TERM       = 3'd7
   } slot_code_type;

   typedef enum logic [2:0] {
      MSG_CREATE    = 3'd0,
      MSG_ACQ_RD    = 3'd1,
      MSG_ACQ_WR    = 3'd2,
      MSG_MALLOC    = 3'd3,
      MSG_RELEASE   = 3'd4,
      MSG_FREE      = 3'd5,
      MSG_TERMINATE = 3'd6
   } msg_code_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_ALLOC,
      OP_NOTIFY,
      OP_RESPONSE,
      OP_STATUS,
      OP_COMPLETE,
      OP_INIT
   } op_type;

   typedef struct packed {
      op_type            op;
      logic              bad_id;
      slot_code_type     alloc_code;
      msg_code_type      msg_code;
      logic [31:0]       msg_object;
      logic [31:0]       msg_value;
      logic [TAG_W-1:0]  tag;
      logic [31:0]       resp_pointer;
      logic [31:0]       resp_size;
   } cmd_type;

endpackage

>>> src/pending_request_slot_table.sv
// Path: a request accepted from the front end is written into the command queue, executed
// from the queue head by the slot engine, and its response is registered onto the rsp_ ports.
// Throughput: one request per cycle; the slot engine executes one command per cycle, so the
// two-entry command queue never holds more than one command and busy stays low.
// Reset: synchronous, active high; all slots free, rotating pointer zero, table not
// initialized, reserved_id 0, id_limit 65536. The response receiver cannot stall.
`timescale 1ns / 1ps

module pending_request_slot_table import prst_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [3:0]           req_type,
   input  logic [31:0]          req_object_id,
   input  logic                 req_acquire_write,
   input  logic [31:0]          req_length,
   input  logic [TAG_W-1:0]     req_tag,
   input  logic [31:0]          req_resp_pointer,
   input  logic [31:0]          req_resp_size,
   input  logic [31:0]          req_address,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic [TAG_W-1:0]     rsp_slot,
   output logic [31:0]          rsp_pointer,
   output logic [31:0]          rsp_size,
   output logic                 rsp_msg_valid,
   output logic [2:0]           rsp_msg_code,
   output logic [TAG_W-1:0]     rsp_msg_tag,
   output logic [31:0]          rsp_msg_object,
   output logic [31:0]          rsp_msg_value,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   logic    queue_full;
   logic    push;
   cmd_type cmd;
   logic    head_valid;
   cmd_type head;
   logic    pop;

   prst_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_object_id     (req_object_id),
      .req_acquire_write (req_acquire_write),
      .req_length        (req_length),
      .req_tag           (req_tag),
      .req_resp_pointer  (req_resp_pointer),
      .req_resp_size     (req_resp_size),
      .req_address       (req_address),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .queue_full        (queue_full),
      .push              (push),
      .cmd               (cmd)
   );

   prst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .din        (cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .dout       (head)
   );

   prst_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_pointer    (rsp_pointer),
      .rsp_size       (rsp_size),
      .rsp_msg_valid  (rsp_msg_valid),
      .rsp_msg_code   (rsp_msg_code),
      .rsp_msg_tag    (rsp_msg_tag),
      .rsp_msg_object (rsp_msg_object),
      .rsp_msg_value  (rsp_msg_value)
   );

endmodule

>>> src/prst_front.sv
// Front end of the pending request slot table.
// Holds the configuration registers, accepts requests and classifies them
// into command words for the queue. Depends on prst_pkg.
`timescale 1ns / 1ps

module prst_front import prst_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [3:0]           req_type,
   input  logic [31:0]          req_object_id,
   input  logic                 req_acquire_write,
   input  logic [31:0]          req_length,
   input  logic [TAG_W-1:0]     req_tag,
   input  logic [31:0]          req_resp_pointer,
   input  logic [31:0]          req_resp_size,
   input  logic [31:0]          req_address,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic                 queue_full,
   output logic                 push,
   output cmd_type              cmd
);

   logic [31:0] reserved_id_ff, reserved_id_in;
   logic [31:0] id_limit_ff, id_limit_in;
   logic        id_bad;

   always_comb begin
      reserved_id_in = reserved_id_ff;
      id_limit_in    = id_limit_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RESERVED_ID: reserved_id_in = csr_wdata;
            CSR_ID_LIMIT:    id_limit_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_id_ff <= RESERVED_ID_RESET;
         id_limit_ff    <= ID_LIMIT_RESET;
      end else begin
         reserved_id_ff <= reserved_id_in;
         id_limit_ff    <= id_limit_in;
      end
   end

   assign busy = queue_full;
   assign push = start && !queue_full;

   always_comb begin
      id_bad = (req_object_id == reserved_id_ff) || (req_object_id >= id_limit_ff);
      cmd = '0;
      cmd.op           = OP_NOP;
      cmd.alloc_code   = CODE_FREE;
      cmd.msg_code     = MSG_CREATE;
      cmd.tag          = req_tag;
      cmd.resp_pointer = req_resp_pointer;
      cmd.resp_size    = req_resp_size;
      case (req_type)
         REQ_CREATE: begin
            cmd.op         = OP_ALLOC;
            cmd.bad_id     = id_bad;
            cmd.alloc_code = CODE_CREATE;
            cmd.msg_code   = MSG_CREATE;
            cmd.msg_object = req_object_id;
            cmd.msg_value  = req_length;
         end
         REQ_ACQUIRE: begin
            cmd.op         = OP_ALLOC;
            cmd.bad_id     = id_bad;
            cmd.alloc_code = req_acquire_write ? CODE_ACQ_WR : CODE_ACQ_RD;
            cmd.msg_code   = req_acquire_write ? MSG_ACQ_WR : MSG_ACQ_RD;
            cmd.msg_object = req_object_id;
         end
         REQ_MALLOC: begin
            cmd.op         = OP_ALLOC;
            cmd.alloc_code = CODE_MALLOC;
            cmd.msg_code   = MSG_MALLOC;
            cmd.msg_value  = req_length;
         end
         REQ_TERMINATE: begin
            cmd.op         = OP_ALLOC;
            cmd.alloc_code = CODE_TERM;
            cmd.msg_code   = MSG_TERMINATE;
         end
         REQ_RELEASE: begin
            cmd.op        = OP_NOTIFY;
            cmd.msg_code  = MSG_RELEASE;
            cmd.msg_value = req_address;
         end
         REQ_FREE: begin
            cmd.op        = OP_NOTIFY;
            cmd.msg_code  = MSG_FREE;
            cmd.msg_value = req_address;
         end
         REQ_RESPONSE:   cmd.op = OP_RESPONSE;
         REQ_STATUS:     cmd.op = OP_STATUS;
         REQ_COMPLETE:   cmd.op = OP_COMPLETE;
         REQ_INITIALIZE: cmd.op = OP_INIT;
         default:        cmd.op = OP_NOP;
      endcase
   end

endmodule

>>> src/prst_queue.sv
// Command queue between the front end and the slot engine.
// A short first-in first-out buffer of command words. Depends on prst_pkg.
`timescale 1ns / 1ps

module prst_queue import prst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type din,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type dout
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign dout       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

>>> src/prst_engine.sv
// Slot engine of the pending request slot table.
// Owns the slot codes, pointers and sizes, executes one queued command per
// cycle and registers the response. Depends on prst_pkg.
`timescale 1ns / 1ps

module prst_engine import prst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cmd_type           head,
   output logic              pop,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [TAG_W-1:0]  rsp_slot,
   output logic [31:0]       rsp_pointer,
   output logic [31:0]       rsp_size,
   output logic              rsp_msg_valid,
   output logic [2:0]        rsp_msg_code,
   output logic [TAG_W-1:0]  rsp_msg_tag,
   output logic [31:0]       rsp_msg_object,
   output logic [31:0]       rsp_msg_value
);

   slot_code_type     slot_code_ff [SLOTS];
   slot_code_type     slot_code_in [SLOTS];
   logic [31:0]       slot_pointer_ff [SLOTS];
   logic [31:0]       slot_size_ff [SLOTS];
   logic [SLOT_W-1:0] next_slot_ff, next_slot_in;
   logic              initialized_ff, initialized_in;

   logic              found;
   logic [SLOT_W-1:0] alloc_idx;
   logic [SLOT_W-1:0] probe;
   logic              take;
   logic              tag_ok;
   logic [SLOT_W-1:0] tag_idx;
   slot_code_type     cur_code;
   logic              ptr_we;
   logic              size_we;

   status_type        status_in;
   logic [TAG_W-1:0]  slot_in;
   logic [31:0]       pointer_in;
   logic [31:0]       size_in;
   logic              msg_valid_in;
   msg_code_type      msg_code_in;
   logic [TAG_W-1:0]  msg_tag_in;
   logic [31:0]       msg_object_in;
   logic [31:0]       msg_value_in;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [TAG_W-1:0]  rsp_slot_ff;
   logic [31:0]       rsp_pointer_ff;
   logic [31:0]       rsp_size_ff;
   logic              rsp_msg_valid_ff;
   msg_code_type      rsp_msg_code_ff;
   logic [TAG_W-1:0]  rsp_msg_tag_ff;
   logic [31:0]       rsp_msg_object_ff;
   logic [31:0]       rsp_msg_value_ff;

   assign pop = head_valid;

   // Round-robin search for a free slot starting at the rotating pointer.
   always_comb begin
      found     = 1'b0;
      alloc_idx = '0;
      probe     = '0;
      for (int k = 0; k < SLOTS; k++) begin
         probe = next_slot_ff + SLOT_W'(k);
         if (!found && slot_code_ff[probe] == CODE_FREE) begin
            found     = 1'b1;
            alloc_idx = probe;
         end
      end
   end

   assign tag_ok   = ({1'b0, head.tag} < (TAG_W + 1)'(SLOTS));
   assign tag_idx  = head.tag[SLOT_W-1:0];
   assign cur_code = slot_code_ff[tag_idx];

   always_comb begin
      slot_code_in   = slot_code_ff;
      next_slot_in   = next_slot_ff;
      initialized_in = initialized_ff;
      ptr_we         = 1'b0;
      size_we        = 1'b0;
      take           = 1'b0;
      status_in      = ST_OK;
      slot_in        = '0;
      pointer_in     = '0;
      size_in        = '0;
      msg_valid_in   = 1'b0;
      msg_code_in    = MSG_CREATE;
      msg_tag_in     = '0;
      msg_object_in  = '0;
      msg_value_in   = '0;
      if (head_valid) begin
         case (head.op)
            OP_ALLOC: begin
               if (head.bad_id) begin
                  status_in = ST_BADID;
               end else if (!initialized_ff) begin
                  status_in = ST_NOINIT;
               end else if (!found) begin
                  status_in = ST_NOSLOT;
               end else begin
                  take                    = 1'b1;
                  slot_code_in[alloc_idx] = head.alloc_code;
                  next_slot_in            = alloc_idx + 1'b1;
                  slot_in                 = TAG_W'(alloc_idx);
                  msg_valid_in            = 1'b1;
                  msg_code_in             = head.msg_code;
                  msg_tag_in              = TAG_W'(alloc_idx);
                  msg_object_in           = head.msg_object;
                  msg_value_in            = head.msg_value;
               end
            end
            OP_NOTIFY: begin
               if (!initialized_ff) begin
                  status_in = ST_NOINIT;
               end else begin
                  msg_valid_in = 1'b1;
                  msg_code_in  = head.msg_code;
                  msg_value_in = head.msg_value;
               end
            end
            OP_RESPONSE: begin
               slot_in = head.tag;
               if (!tag_ok) begin
                  status_in = ST_BADTAG;
               end else begin
                  case (cur_code)
                     CODE_TERM: initialized_in = 1'b0;
                     CODE_CREATE, CODE_ACQ_RD, CODE_ACQ_WR: begin
                        slot_code_in[tag_idx] = CODE_DATA_RDY;
                        ptr_we                = 1'b1;
                        size_we               = 1'b1;
                     end
                     CODE_MALLOC: begin
                        slot_code_in[tag_idx] = CODE_MALLOC_RDY;
                        ptr_we                = 1'b1;
                     end
                     default: status_in = ST_BADTAG;
                  endcase
               end
            end
            OP_STATUS, OP_COMPLETE: begin
               slot_in = head.tag;
               if (!tag_ok) begin
                  status_in = ST_BADTAG;
               end else begin
                  case (cur_code)
                     CODE_CREATE, CODE_ACQ_RD, CODE_ACQ_WR, CODE_MALLOC: begin
                        status_in = ST_BUSY;
                     end
                     CODE_DATA_RDY, CODE_MALLOC_RDY: begin
                        if (head.op == OP_STATUS) begin
                           status_in = ST_READY;
                        end else begin
                           pointer_in            = slot_pointer_ff[tag_idx];
                           size_in               = (cur_code == CODE_DATA_RDY) ?
                                                   slot_size_ff[tag_idx] : '0;
                           slot_code_in[tag_idx] = CODE_FREE;
                        end
                     end
                     default: status_in = ST_BADTAG;
                  endcase
               end
            end
            OP_INIT: begin
               for (int k = 0; k < SLOTS; k++) begin
                  slot_code_in[k] = CODE_FREE;
               end
               initialized_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) begin
            slot_code_ff[k] <= CODE_FREE;
         end
         next_slot_ff   <= '0;
         initialized_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         slot_code_ff   <= slot_code_in;
         next_slot_ff   <= next_slot_in;
         initialized_ff <= initialized_in;
         rsp_valid_ff   <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ptr_we) begin
         slot_pointer_ff[tag_idx] <= head.resp_pointer;
      end
      if (size_we) begin
         slot_size_ff[tag_idx] <= head.resp_size;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff     <= status_in;
      rsp_slot_ff       <= slot_in;
      rsp_pointer_ff    <= pointer_in;
      rsp_size_ff       <= size_in;
      rsp_msg_valid_ff  <= msg_valid_in;
      rsp_msg_code_ff   <= msg_code_in;
      rsp_msg_tag_ff    <= msg_tag_in;
      rsp_msg_object_ff <= msg_object_in;
      rsp_msg_value_ff  <= msg_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_pointer    = rsp_pointer_ff;
   assign rsp_size       = rsp_size_ff;
   assign rsp_msg_valid  = rsp_msg_valid_ff;
   assign rsp_msg_code   = rsp_msg_code_ff;
   assign rsp_msg_tag    = rsp_msg_tag_ff;
   assign rsp_msg_object = rsp_msg_object_ff;
   assign rsp_msg_value  = rsp_msg_value_ff;

   a_rsp_follows_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(head_valid))
      else $error("Response without a command executed in the previous cycle.");

   a_msg_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_msg_valid_ff) |-> (rsp_status_ff == ST_OK))
      else $error("Outgoing message carries a failing status.");

   a_take_free_slot: assert property (@(posedge clock) disable iff (reset)
      take |-> (slot_code_ff[alloc_idx] == CODE_FREE))
      else $error("Allocation picked a slot that is not free.");

   a_pointer_advance: assert property (@(posedge clock) disable iff (reset)
      take |=> (next_slot_ff == $past(alloc_idx + 1'b1)))
      else $error("Rotating pointer did not move past the allocated slot.");

endmodule
